// ===== hw/rtl/b2da_pkg.sv =====
// Shared types, constants and the double-dabble step for the decimal text converter.
`default_nettype none
package b2da_pkg;

  localparam int BinWidth   = 32;
  localparam int NumDigits  = 10;
  localparam int BcdWidth   = 4 * NumDigits;
  localparam int StepsPerStage = 8;
  localparam logic [5:0] CharZero = 6'h30;

  typedef struct packed {
    logic [BinWidth-1:0] bin;
    logic [BcdWidth-1:0] bcd;
  } b2da_work_t;

  function automatic b2da_work_t b2da_dabble(input b2da_work_t w);
    b2da_work_t r;
    logic [BcdWidth-1:0] adj;
    r = w;
    for (int s = 0; s < StepsPerStage; s++) begin
      adj = r.bcd;
      for (int d = 0; d < NumDigits; d++) begin
        if (adj[4*d +: 4] >= 4'd5) begin
          adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
        end
      end
      r.bcd = {adj[BcdWidth-2:0], r.bin[BinWidth-1]};
      r.bin = {r.bin[BinWidth-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/b2da_stage.sv =====
// One pipeline stage of the binary to BCD conversion, eight shift-add steps.
`default_nettype none
module b2da_stage import b2da_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic       valid_i,
  input  wire b2da_work_t work_i,
  output logic            valid_o,
  output b2da_work_t      work_o
);

  logic       valid_q;
  b2da_work_t work_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q <= b2da_dabble(work_i);
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule
`default_nettype wire

// ===== hw/rtl/b2da_emit.sv =====
// Serialiser that sends the BCD digits as ASCII characters, most significant first.
`default_nettype none
module b2da_emit import b2da_pkg::*; #(
  parameter int MAX_DIGITS = 10
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire logic [BcdWidth-1:0] bcd_i,
  output logic                     ready_o,
  output logic                     valid_o,
  output logic [5:0]               digit_char_o,
  output logic                     last_o
);

  localparam int Lim = (MAX_DIGITS < NumDigits) ? MAX_DIGITS : NumDigits;
  localparam logic [3:0] LimW = 4'(Lim);

  logic                active_q;
  logic [3:0]          idx_q, idx_d;
  logic [BcdWidth-1:0] bcd_q;
  logic [3:0]          count;

  always_comb begin
    count = 4'd1;
    for (int d = 0; d < NumDigits; d++) begin
      if (bcd_i[4*d +: 4] != 4'd0) begin
        count = 4'(d + 1);
      end
    end
    if (count > LimW) begin
      count = LimW;
    end
    idx_d = count - 4'd1;
  end

  assign ready_o = !active_q || (idx_q == 4'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= 4'd0;
    end else if (load_i) begin
      active_q <= 1'b1;
      idx_q    <= idx_d;
    end else if (active_q) begin
      if (idx_q == 4'd0) begin
        active_q <= 1'b0;
      end else begin
        idx_q <= idx_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bcd_q <= bcd_i;
    end
  end

  assign valid_o      = active_q;
  assign digit_char_o = CharZero + {2'b00, bcd_q[4*idx_q +: 4]};
  assign last_o       = (idx_q == 4'd0);

endmodule
`default_nettype wire

// ===== hw/rtl/binary_to_decimal_ascii.sv =====
// Top level: 32-bit binary to decimal ASCII characters with leading zeros suppressed.
// Each value passes through the four shift-add conversion stages and is then loaded into the serialiser.
// Throughput: one character per cycle while a value is being sent; each digit, up to MAX_DIGITS, gives one character.
// The four conversion stages take a new value each cycle while the serialiser keeps up.
// Reset clears all valid bits and the serialiser; the receiver cannot stall.
`default_nettype none
module binary_to_decimal_ascii import b2da_pkg::*; #(
  parameter int MAX_DIGITS = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [31:0] value_i,
  output logic             valid_o,
  output logic [5:0]       digit_char_o,
  output logic             last_o
);

  localparam int NumStages = BinWidth / StepsPerStage;

  logic       valid_s [NumStages+1];
  b2da_work_t work_s  [NumStages+1];
  logic       emit_ready;
  logic       advance;

  assign advance = !valid_s[NumStages] || emit_ready;
  assign busy_o  = !advance;

  assign valid_s[0]    = start_i && advance;
  assign work_s[0].bin = value_i;
  assign work_s[0].bcd = '0;

  for (genvar g = 0; g < NumStages; g++) begin : g_stage
    b2da_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .valid_i (valid_s[g]),
      .work_i  (work_s[g]),
      .valid_o (valid_s[g+1]),
      .work_o  (work_s[g+1])
    );
  end

  b2da_emit #(.MAX_DIGITS(MAX_DIGITS)) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (valid_s[NumStages] && emit_ready),
    .bcd_i        (work_s[NumStages].bcd),
    .ready_o      (emit_ready),
    .valid_o      (valid_o),
    .digit_char_o (digit_char_o),
    .last_o       (last_o)
  );

endmodule
`default_nettype wire
